FILE: hw/rtl/pmx_pkg.sv
// shared constants and types for the partially mapped crossover engine
// no dependencies

package pmx_pkg;

  localparam int MAX_GENES  = 64;
  localparam int GENE_W     = 6;
  localparam int GENE_SPACE = 1 << GENE_W;
  localparam int CFG_W      = 7;
  localparam int POS_W      = $clog2(MAX_GENES);
  localparam int CNT_W      = $clog2(MAX_GENES + 1);
  localparam int CMP_W0     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int CMP_W      = (CMP_W0 > GENE_W) ? CMP_W0 : GENE_W;
  localparam logic [CFG_W-1:0] GENE_COUNT_RST = CFG_W'(64);

  typedef struct packed {
    logic              wr_en;
    logic              clr;
    logic [GENE_W-1:0] wr_addr;
    logic [GENE_W-1:0] wr_data;
  } pmx_map_ctl_t;

endpackage

FILE: hw/rtl/pmx_map_table.sv
// one mapping table: target memory with a registered read and per-entry valid bits
// depends on pmx_pkg

module pmx_map_table (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pmx_pkg::pmx_map_ctl_t      ctl,
  input  logic [pmx_pkg::GENE_W-1:0] rd_addr,
  output logic [pmx_pkg::GENE_W-1:0] rd_data,
  output logic                       rd_hit
);

  logic [pmx_pkg::GENE_W-1:0]     mem [pmx_pkg::GENE_SPACE];
  logic [pmx_pkg::GENE_W-1:0]     rd_data_r;
  logic [pmx_pkg::GENE_SPACE-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      vld_r <= '0;
    end else if (ctl.wr_en) begin
      vld_r[ctl.wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_data_r;
  assign rd_hit  = vld_r[rd_addr];

endmodule

FILE: hw/rtl/pmx_crossover_engine_top.sv
// top level of the partially mapped crossover engine, built on pmx_pkg and pmx_map_table
// load: a transfer is taken whenever start is high while idle; error result in the cycle after the final load transfer
// map fill: per segment position, a parent memory read state, then a table write state
// emit: read then select per segment position; elsewhere read, select and chase, plus chase and update per chain step
// results leave one at a time, never back to back; busy until the last one; receiver cannot stall
// reset (synchronous, rst_n low) sets gene_count to 64, clears the load pointer and valid bits

module pmx_crossover_engine_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [pmx_pkg::GENE_W-1:0]  in_gene_a,
  input  logic [pmx_pkg::GENE_W-1:0]  in_gene_b,
  input  logic [pmx_pkg::GENE_W-1:0]  in_cut_start,
  input  logic [pmx_pkg::GENE_W-1:0]  in_cut_end,
  input  logic                        cfg_we,
  input  logic [pmx_pkg::CFG_W-1:0]   cfg_wdata,
  output logic                        out_valid,
  output logic [pmx_pkg::GENE_W-1:0]  out_position,
  output logic [pmx_pkg::GENE_W-1:0]  out_child_a_gene,
  output logic [pmx_pkg::GENE_W-1:0]  out_child_b_gene,
  output logic                        out_last,
  output logic                        out_bad_cut
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP_RD,
    S_MAP_WR,
    S_EMIT_RD,
    S_EMIT_SEL,
    S_CHASE,
    S_CHASE_UPD
  } state_t;

  state_t state_r;

  logic [pmx_pkg::CFG_W-1:0]  gene_count_r;
  logic [pmx_pkg::POS_W-1:0]  load_pos_r;
  logic [pmx_pkg::POS_W-1:0]  idx_r;
  logic [pmx_pkg::POS_W-1:0]  seg_start_r;
  logic [pmx_pkg::POS_W-1:0]  seg_end_r;
  logic [pmx_pkg::GENE_W-1:0] va_r;
  logic [pmx_pkg::GENE_W-1:0] vb_r;
  logic [pmx_pkg::CNT_W-1:0]  steps_a_r;
  logic [pmx_pkg::CNT_W-1:0]  steps_b_r;
  logic                       go_a_r;
  logic                       go_b_r;
  logic                       map_clr_r;

  logic                       out_valid_r;
  logic [pmx_pkg::GENE_W-1:0] out_position_r;
  logic [pmx_pkg::GENE_W-1:0] out_child_a_r;
  logic [pmx_pkg::GENE_W-1:0] out_child_b_r;
  logic                       out_last_r;
  logic                       out_bad_cut_r;

  logic [pmx_pkg::GENE_W-1:0] par_a_mem [pmx_pkg::MAX_GENES];
  logic [pmx_pkg::GENE_W-1:0] par_b_mem [pmx_pkg::MAX_GENES];
  logic [pmx_pkg::GENE_W-1:0] par_a_q_r;
  logic [pmx_pkg::GENE_W-1:0] par_b_q_r;

  logic [pmx_pkg::CMP_W-1:0]  gc_cmp;
  logic [pmx_pkg::CMP_W-1:0]  n_cmp;
  logic [pmx_pkg::CNT_W-1:0]  n_cnt;
  logic                       accept;
  logic [pmx_pkg::POS_W-1:0]  pos_eff;
  logic                       load_done;
  logic                       cut_bad;
  logic                       in_seg;
  logic                       idx_last;
  logic                       cont_a;
  logic                       cont_b;

  pmx_pkg::pmx_map_ctl_t      ctl_a;
  pmx_pkg::pmx_map_ctl_t      ctl_b;
  logic [pmx_pkg::GENE_W-1:0] map_a_q;
  logic [pmx_pkg::GENE_W-1:0] map_b_q;
  logic                       map_a_hit;
  logic                       map_b_hit;

  // effective gene count, clamped to the supported range
  always_comb begin
    gc_cmp = pmx_pkg::CMP_W'(gene_count_r);
    priority if (gc_cmp < pmx_pkg::CMP_W'(2)) begin
      n_cmp = pmx_pkg::CMP_W'(2);
    end else if (gc_cmp > pmx_pkg::CMP_W'(pmx_pkg::MAX_GENES)) begin
      n_cmp = pmx_pkg::CMP_W'(pmx_pkg::MAX_GENES);
    end else begin
      n_cmp = gc_cmp;
    end
  end

  assign n_cnt     = pmx_pkg::CNT_W'(n_cmp);
  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign pos_eff   = (pmx_pkg::CMP_W'(load_pos_r) >= n_cmp) ? '0 : load_pos_r;
  assign load_done = (pmx_pkg::CMP_W'(pos_eff) + pmx_pkg::CMP_W'(1)) >= n_cmp;
  assign cut_bad   = (in_cut_start > in_cut_end)
                     || (pmx_pkg::CMP_W'(in_cut_end) >= n_cmp);
  assign in_seg    = (idx_r >= seg_start_r) && (idx_r <= seg_end_r);
  assign idx_last  = (pmx_pkg::CMP_W'(idx_r) + pmx_pkg::CMP_W'(1)) == n_cmp;
  assign cont_a    = map_a_hit && (steps_a_r < n_cnt);
  assign cont_b    = map_b_hit && (steps_b_r < n_cnt);

  // parent stores
  always_ff @(posedge clk) begin
    if (accept) begin
      par_a_mem[pos_eff] <= in_gene_a;
      par_b_mem[pos_eff] <= in_gene_b;
    end
    par_a_q_r <= par_a_mem[idx_r];
    par_b_q_r <= par_b_mem[idx_r];
  end

  // map a: b gene -> a gene, map b: a gene -> b gene
  always_comb begin
    ctl_a.wr_en   = (state_r == S_MAP_WR);
    ctl_a.clr     = map_clr_r;
    ctl_a.wr_addr = par_b_q_r;
    ctl_a.wr_data = par_a_q_r;
    ctl_b.wr_en   = (state_r == S_MAP_WR);
    ctl_b.clr     = map_clr_r;
    ctl_b.wr_addr = par_a_q_r;
    ctl_b.wr_data = par_b_q_r;
  end

  pmx_map_table u_map_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl_a),
    .rd_addr (va_r),
    .rd_data (map_a_q),
    .rd_hit  (map_a_hit)
  );

  pmx_map_table u_map_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl_b),
    .rd_addr (vb_r),
    .rd_data (map_b_q),
    .rd_hit  (map_b_hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      gene_count_r <= pmx_pkg::GENE_COUNT_RST;
      load_pos_r   <= '0;
      map_clr_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      map_clr_r   <= 1'b0;
      if (cfg_we) begin
        gene_count_r <= cfg_wdata;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (!load_done) begin
              load_pos_r <= pos_eff + pmx_pkg::POS_W'(1);
            end else begin
              load_pos_r <= '0;
              if (cut_bad) begin
                out_valid_r    <= 1'b1;
                out_position_r <= '0;
                out_child_a_r  <= '0;
                out_child_b_r  <= '0;
                out_last_r     <= 1'b1;
                out_bad_cut_r  <= 1'b1;
              end else begin
                seg_start_r <= pmx_pkg::POS_W'(in_cut_start);
                seg_end_r   <= pmx_pkg::POS_W'(in_cut_end);
                idx_r       <= pmx_pkg::POS_W'(in_cut_start);
                state_r     <= S_MAP_RD;
              end
            end
          end
        end
        S_MAP_RD: begin
          state_r <= S_MAP_WR;
        end
        S_MAP_WR: begin
          if (idx_r == seg_end_r) begin
            idx_r   <= '0;
            state_r <= S_EMIT_RD;
          end else begin
            idx_r   <= idx_r + pmx_pkg::POS_W'(1);
            state_r <= S_MAP_RD;
          end
        end
        S_EMIT_RD: begin
          state_r <= S_EMIT_SEL;
        end
        S_EMIT_SEL: begin
          if (in_seg) begin
            out_valid_r    <= 1'b1;
            out_position_r <= pmx_pkg::GENE_W'(idx_r);
            out_child_a_r  <= par_b_q_r;
            out_child_b_r  <= par_a_q_r;
            out_last_r     <= idx_last;
            out_bad_cut_r  <= 1'b0;
            if (idx_last) begin
              map_clr_r <= 1'b1;
              state_r   <= S_IDLE;
            end else begin
              idx_r   <= idx_r + pmx_pkg::POS_W'(1);
              state_r <= S_EMIT_RD;
            end
          end else begin
            va_r      <= par_a_q_r;
            vb_r      <= par_b_q_r;
            steps_a_r <= '0;
            steps_b_r <= '0;
            state_r   <= S_CHASE;
          end
        end
        S_CHASE: begin
          if (!cont_a && !cont_b) begin
            out_valid_r    <= 1'b1;
            out_position_r <= pmx_pkg::GENE_W'(idx_r);
            out_child_a_r  <= va_r;
            out_child_b_r  <= vb_r;
            out_last_r     <= idx_last;
            out_bad_cut_r  <= 1'b0;
            if (idx_last) begin
              map_clr_r <= 1'b1;
              state_r   <= S_IDLE;
            end else begin
              idx_r   <= idx_r + pmx_pkg::POS_W'(1);
              state_r <= S_EMIT_RD;
            end
          end else begin
            go_a_r  <= cont_a;
            go_b_r  <= cont_b;
            state_r <= S_CHASE_UPD;
          end
        end
        S_CHASE_UPD: begin
          if (go_a_r) begin
            va_r      <= map_a_q;
            steps_a_r <= steps_a_r + pmx_pkg::CNT_W'(1);
          end
          if (go_b_r) begin
            vb_r      <= map_b_q;
            steps_b_r <= steps_b_r + pmx_pkg::CNT_W'(1);
          end
          state_r <= S_CHASE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_position     = out_position_r;
  assign out_child_a_gene = out_child_a_r;
  assign out_child_b_gene = out_child_b_r;
  assign out_last         = out_last_r;
  assign out_bad_cut      = out_bad_cut_r;

endmodule

FILE: tb/sv/pmx_offspring_checker.sv
`timescale 1ns / 1ps
// offspring checker for the crossover engine: follows the load, config and result ports,
// works out the children of every crossover and compares each result transfer in order
// depends on pmx_pkg

module pmx_offspring_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic [pmx_pkg::GENE_W-1:0] in_gene_a,
  input  logic [pmx_pkg::GENE_W-1:0] in_gene_b,
  input  logic [pmx_pkg::GENE_W-1:0] in_cut_start,
  input  logic [pmx_pkg::GENE_W-1:0] in_cut_end,
  input  logic                       cfg_we,
  input  logic [pmx_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                       out_valid,
  input  logic [pmx_pkg::GENE_W-1:0] out_position,
  input  logic [pmx_pkg::GENE_W-1:0] out_child_a_gene,
  input  logic [pmx_pkg::GENE_W-1:0] out_child_b_gene,
  input  logic                       out_last,
  input  logic                       out_bad_cut,
  output int                         mismatch_count,
  output int                         results_owed
);

  typedef struct packed {
    logic [pmx_pkg::GENE_W-1:0] position;
    logic [pmx_pkg::GENE_W-1:0] child_a;
    logic [pmx_pkg::GENE_W-1:0] child_b;
    logic                       last;
    logic                       bad_cut;
  } offspring_t;

  logic [pmx_pkg::GENE_W-1:0] parent_a[pmx_pkg::MAX_GENES];
  logic [pmx_pkg::GENE_W-1:0] parent_b[pmx_pkg::MAX_GENES];
  logic [pmx_pkg::GENE_W-1:0] map_a_to[pmx_pkg::GENE_SPACE];
  logic                       map_a_set[pmx_pkg::GENE_SPACE];
  logic [pmx_pkg::GENE_W-1:0] map_b_to[pmx_pkg::GENE_SPACE];
  logic                       map_b_set[pmx_pkg::GENE_SPACE];
  logic [pmx_pkg::CFG_W-1:0]  gene_count;
  int                         load_pos;
  int                         errors;
  offspring_t                 offspring_q[$];

  function automatic int genes_in_use();
    if (gene_count < 2) return 2;
    if (gene_count > pmx_pkg::MAX_GENES) return pmx_pkg::MAX_GENES;
    return int'(gene_count);
  endfunction

  function automatic void expect_offspring(input offspring_t kid);
    offspring_q.insert(offspring_q.size(), kid);
  endfunction

  function automatic logic [pmx_pkg::GENE_W-1:0] walk_chain(
      input logic use_b, input logic [pmx_pkg::GENE_W-1:0] gene, input int limit);
    logic [pmx_pkg::GENE_W-1:0] v;
    int                         steps;
    v = gene;
    steps = 0;
    while ((use_b ? map_b_set[v] : map_a_set[v]) && steps < limit) begin
      v = use_b ? map_b_to[v] : map_a_to[v];
      steps++;
    end
    return v;
  endfunction

  function automatic void cross_parents(input int cs, input int ce, input int n);
    offspring_t kid;
    for (int g = 0; g < pmx_pkg::GENE_SPACE; g++) begin
      map_a_set[g] = 1'b0;
      map_b_set[g] = 1'b0;
    end
    if (cs > ce || ce >= n) begin
      kid = '{position: '0, child_a: '0, child_b: '0, last: 1'b1, bad_cut: 1'b1};
      expect_offspring(kid);
      return;
    end
    for (int i = cs; i <= ce; i++) begin
      map_a_to[parent_b[i]]  = parent_a[i];
      map_a_set[parent_b[i]] = 1'b1;
      map_b_to[parent_a[i]]  = parent_b[i];
      map_b_set[parent_a[i]] = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      kid.position = pmx_pkg::GENE_W'(i);
      kid.last     = (i == n - 1);
      kid.bad_cut  = 1'b0;
      if (i >= cs && i <= ce) begin
        kid.child_a = parent_b[i];
        kid.child_b = parent_a[i];
      end else begin
        kid.child_a = walk_chain(1'b0, parent_a[i], n);
        kid.child_b = walk_chain(1'b1, parent_b[i], n);
      end
      expect_offspring(kid);
    end
  endfunction

  always @(posedge clk) begin
    offspring_t got;
    offspring_t want;
    int         n;
    int         pos;
    if (!rst_n) begin
      gene_count = pmx_pkg::GENE_COUNT_RST;
      load_pos   = 0;
      errors     = 0;
      offspring_q.delete();
    end else begin
      if (out_valid) begin
        got = '{position: out_position, child_a: out_child_a_gene,
                child_b: out_child_b_gene, last: out_last, bad_cut: out_bad_cut};
        if (offspring_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result transfer pos=%0d a=%0d b=%0d last=%0b bad=%0b",
                     $realtime, got.position, got.child_a, got.child_b, got.last,
                     got.bad_cut);
        end else begin
          want = offspring_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display({"%0t: result mismatch expected pos=%0d a=%0d b=%0d last=%0b ",
                        "bad=%0b, got pos=%0d a=%0d b=%0d last=%0b bad=%0b"},
                       $realtime, want.position, want.child_a, want.child_b, want.last,
                       want.bad_cut, got.position, got.child_a, got.child_b, got.last,
                       got.bad_cut);
          end
        end
      end
      if (cfg_we)
        gene_count = cfg_wdata;
      if (start && !busy) begin
        n   = genes_in_use();
        pos = (load_pos >= n) ? 0 : load_pos;
        parent_a[pos] = in_gene_a;
        parent_b[pos] = in_gene_b;
        if (pos + 1 < n) begin
          load_pos = pos + 1;
        end else begin
          load_pos = 0;
          cross_parents(int'(in_cut_start), int'(in_cut_end), n);
        end
      end
    end
    mismatch_count <= errors;
    results_owed   <= offspring_q.size();
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// top of the crossover engine testbench: clock, reset, load and config stimulus, verdict
// depends on pmx_pkg, pmx_crossover_engine_top and pmx_offspring_checker

module tb;

  localparam int SETTLE         = 160;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_ITEMS   = 132;

  logic                       clk          = 1'b0;
  logic                       rst_n        = 1'b0;
  logic                       start        = 1'b0;
  logic [pmx_pkg::GENE_W-1:0] in_gene_a    = '0;
  logic [pmx_pkg::GENE_W-1:0] in_gene_b    = '0;
  logic [pmx_pkg::GENE_W-1:0] in_cut_start = '0;
  logic [pmx_pkg::GENE_W-1:0] in_cut_end   = '0;
  logic                       cfg_we       = 1'b0;
  logic [pmx_pkg::CFG_W-1:0]  cfg_wdata    = '0;
  logic                       busy;
  logic                       out_valid;
  logic [pmx_pkg::GENE_W-1:0] out_position;
  logic [pmx_pkg::GENE_W-1:0] out_child_a_gene;
  logic [pmx_pkg::GENE_W-1:0] out_child_b_gene;
  logic                       out_last;
  logic                       out_bad_cut;
  int                         mismatch_count;
  int                         results_owed;

  int                         burst_left = 0;
  int                         items_sent = 0;
  int                         quiet_cycles = 0;
  int                         genes_now = 64;
  logic [pmx_pkg::GENE_W-1:0] gene_pool[pmx_pkg::GENE_SPACE];
  logic [pmx_pkg::GENE_W-1:0] genes_a[pmx_pkg::MAX_GENES];
  logic [pmx_pkg::GENE_W-1:0] genes_b[pmx_pkg::MAX_GENES];

  always #10 clk = ~clk;

  pmx_crossover_engine_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_gene_a        (in_gene_a),
    .in_gene_b        (in_gene_b),
    .in_cut_start     (in_cut_start),
    .in_cut_end       (in_cut_end),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_position     (out_position),
    .out_child_a_gene (out_child_a_gene),
    .out_child_b_gene (out_child_b_gene),
    .out_last         (out_last),
    .out_bad_cut      (out_bad_cut)
  );

  pmx_offspring_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_gene_a        (in_gene_a),
    .in_gene_b        (in_gene_b),
    .in_cut_start     (in_cut_start),
    .in_cut_end       (in_cut_end),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_position     (out_position),
    .out_child_a_gene (out_child_a_gene),
    .out_child_b_gene (out_child_b_gene),
    .out_last         (out_last),
    .out_bad_cut      (out_bad_cut),
    .mismatch_count   (mismatch_count),
    .results_owed     (results_owed)
  );

  // no transfer on either side for too long ends the run
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_gene_pair(input int ga, input int gb, input int cs, input int ce);
    start        <= 1'b1;
    in_gene_a    <= pmx_pkg::GENE_W'(ga);
    in_gene_b    <= pmx_pkg::GENE_W'(gb);
    in_cut_start <= pmx_pkg::GENE_W'(cs);
    in_cut_end   <= pmx_pkg::GENE_W'(ce);
    do @(posedge clk); while (busy);
    items_sent++;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain_and_settle();
    start <= 1'b0;
    do @(posedge clk); while (results_owed != 0 || busy);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_gene_count(input int value);
    drain_and_settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= pmx_pkg::CFG_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    genes_now = (value < 2) ? 2 : (value > pmx_pkg::MAX_GENES) ? pmx_pkg::MAX_GENES : value;
  endtask

  task automatic shuffle_pool(input int n);
    logic [pmx_pkg::GENE_W-1:0] tmp;
    int                         j;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = gene_pool[i];
      gene_pool[i] = gene_pool[j];
      gene_pool[j] = tmp;
    end
  endtask

  initial begin
    int random_base;
    int n;
    int kind;
    int cs;
    int ce;
    int pick;
    bit wrote_big_max;
    bit first_run;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // smallest count, full swap
    write_gene_count(2);
    send_gene_pair(63, 0, 17, 40);
    send_gene_pair(0, 63, 0, 1);
    // start after end
    send_gene_pair(5, 9, 3, 3);
    send_gene_pair(9, 5, 1, 0);
    // end beyond the chromosome
    send_gene_pair(1, 2, 0, 0);
    send_gene_pair(2, 1, 0, 2);
    // count below range clamps up
    write_gene_count(0);
    send_gene_pair(0, 1, 0, 0);
    send_gene_pair(1, 0, 1, 1);
    // mapping loop, chain walk stopped by the step limit
    write_gene_count(4);
    send_gene_pair(2, 7, 0, 0);
    send_gene_pair(2, 3, 0, 0);
    send_gene_pair(3, 2, 0, 0);
    send_gene_pair(9, 2, 1, 2);
    // repeated keys in the segment, last one wins
    send_gene_pair(4, 6, 0, 0);
    send_gene_pair(5, 6, 0, 0);
    send_gene_pair(7, 6, 0, 0);
    send_gene_pair(6, 4, 0, 2);
    // count lowered part way through a load
    send_gene_pair(11, 12, 0, 0);
    send_gene_pair(12, 13, 0, 0);
    send_gene_pair(13, 11, 0, 0);
    write_gene_count(2);
    send_gene_pair(21, 22, 0, 0);
    send_gene_pair(22, 21, 0, 1);
    // extreme genes and cut points
    write_gene_count(3);
    send_gene_pair(63, 63, 63, 0);
    send_gene_pair(0, 0, 0, 63);
    send_gene_pair(63, 0, 63, 63);

    for (int g = 0; g < pmx_pkg::GENE_SPACE; g++) gene_pool[g] = pmx_pkg::GENE_W'(g);
    random_base   = items_sent;
    wrote_big_max = 1'b0;
    first_run     = 1'b1;
    while (items_sent - random_base < RANDOM_ITEMS) begin
      if (first_run) begin
        write_gene_count(127);
        first_run = 1'b0;
      end else if (!wrote_big_max && items_sent - random_base >= 70) begin
        write_gene_count(64);
        wrote_big_max = 1'b1;
      end else if (genes_now == pmx_pkg::MAX_GENES || $urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, 5);
        write_gene_count(pick == 0 ? $urandom_range(0, 1) : $urandom_range(2, 10));
      end
      n = genes_now;
      kind = $urandom_range(0, 9);
      shuffle_pool(pmx_pkg::GENE_SPACE);
      for (int i = 0; i < n; i++) genes_a[i] = gene_pool[i];
      shuffle_pool(n);
      for (int i = 0; i < n; i++) genes_b[i] = gene_pool[i];
      // mostly true permutations of one gene set, the rest noise with repeats
      if (kind == 7) begin
        for (int i = 0; i < n; i++) begin
          genes_a[i] = pmx_pkg::GENE_W'($urandom_range(0, 7));
          genes_b[i] = pmx_pkg::GENE_W'($urandom_range(0, 7));
        end
      end else if (kind == 8) begin
        for (int i = 0; i < n; i++) begin
          genes_a[i] = pmx_pkg::GENE_W'($urandom_range(0, 63));
          genes_b[i] = pmx_pkg::GENE_W'($urandom_range(0, 63));
        end
      end
      if (kind == 9 || $urandom_range(0, 9) == 0) begin
        cs = $urandom_range(0, 63);
        ce = $urandom_range(0, 63);
      end else begin
        cs = $urandom_range(0, n - 1);
        ce = $urandom_range(cs, n - 1);
      end
      for (int i = 0; i < n - 1; i++)
        send_gene_pair(genes_a[i], genes_b[i], $urandom_range(0, 63), $urandom_range(0, 63));
      send_gene_pair(genes_a[n-1], genes_b[n-1], cs, ce);
      // hold off until the whole crossover has come out
      if ($urandom_range(0, 7) == 0) drain_and_settle();
    end

    drain_and_settle();
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
